// ----- design/mcpid_pkg.sv -----
// ----------------------------------------------------------------------------
// mcpid_pkg
// Shared types and constants for the multi-channel PID speed loop.
// ----------------------------------------------------------------------------
package mcpid_pkg;

  localparam int unsigned ChannelsDefault = 4;
  localparam int unsigned QueueDepth      = 4;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FF_GAIN   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OUT_LIMIT = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_INT_LIMIT = 3'd5;

  localparam logic [14:0] OutLimitReset = 15'd1000;
  localparam logic [14:0] IntLimitReset = 15'd300;

  typedef enum logic [1:0] {
    KIND_STEP  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_BAD   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic        [2:0]  ch;
    logic signed [16:0] err;
    logic signed [15:0] target;
  } entry_t;

  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic        [15:0] ff_gain;
    logic        [14:0] out_limit;
    logic        [14:0] int_limit;
  } cfg_t;

endpackage

// ----- design/mcpid_front.sv -----
// ----------------------------------------------------------------------------
// mcpid_front
// Input stage: takes a beat, classifies it and forms the speed error.
// ----------------------------------------------------------------------------
module mcpid_front #(
  parameter int unsigned CHANNELS = mcpid_pkg::ChannelsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,  // speed_target, speed_measured
  input  logic [3:0]          s_axis_tuser,  // channel, mode
  output logic                push_o,
  output mcpid_pkg::entry_t   entry_o,
  input  logic                full_i
);
  import mcpid_pkg::*;

  logic   front_valid_q;
  entry_t entry_q;
  entry_t entry_d;
  logic   take;

  assign s_axis_tready = !front_valid_q || !full_i;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign push_o        = front_valid_q && !full_i;
  assign entry_o       = entry_q;

  always_comb begin
    entry_d.ch     = s_axis_tuser[2:0];
    entry_d.target = $signed(s_axis_tdata[15:0]);
    entry_d.err    = 17'($signed(s_axis_tdata[15:0])) - 17'($signed(s_axis_tdata[31:16]));
    if ({1'b0, s_axis_tuser[2:0]} >= 4'(CHANNELS)) begin
      entry_d.kind = KIND_BAD;
    end else if (s_axis_tuser[3]) begin
      entry_d.kind = KIND_CLEAR;
    end else begin
      entry_d.kind = KIND_STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
    end else if (take) begin
      front_valid_q <= 1'b1;
    end else if (push_o) begin
      front_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      entry_q <= entry_d;
    end
  end

endmodule

// ----- design/mcpid_queue.sv -----
// ----------------------------------------------------------------------------
// mcpid_queue
// Small FIFO between the front stage and the compute pipeline.
// ----------------------------------------------------------------------------
module mcpid_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mcpid_pkg::entry_t entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output mcpid_pkg::entry_t entry_o
);
  import mcpid_pkg::*;

  localparam int unsigned AddrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned PtrW  = AddrW + 1;

  entry_t          mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;

  assign valid_o = wr_ptr_q != rd_ptr_q;
  assign full_o  = (wr_ptr_q[AddrW-1:0] == rd_ptr_q[AddrW-1:0]) &&
                   (wr_ptr_q[PtrW-1] != rd_ptr_q[PtrW-1]);
  assign entry_o = mem_q[rd_ptr_q[AddrW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i && valid_o) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q[AddrW-1:0]] <= entry_i;
    end
  end

endmodule

// ----- design/mcpid_back.sv -----
// ----------------------------------------------------------------------------
// mcpid_back
// Compute pipeline: per-channel state update, products, scaling and clamps.
// ----------------------------------------------------------------------------
module mcpid_back #(
  parameter int unsigned CHANNELS = mcpid_pkg::ChannelsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mcpid_pkg::cfg_t   cfg_i,
  input  logic              q_valid_i,
  input  mcpid_pkg::entry_t q_entry_i,
  output logic              pop_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,  // drive
  output logic [0:0]        m_axis_tuser   // channel_ok
);
  import mcpid_pkg::*;

  localparam int unsigned ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // per-channel state
  logic signed [15:0] integ_q [CHANNELS];
  logic signed [16:0] prev_q  [CHANNELS];
  logic               first_q [CHANNELS];

  logic adv;

  // stage 1: state read-modify-write
  logic [ChIdxW-1:0]  idx;
  logic signed [17:0] isum;
  logic signed [17:0] ilim;
  logic signed [15:0] integ_d;
  logic signed [16:0] prev_eff;
  logic signed [17:0] deriv_d;

  logic               s1_valid_q;
  kind_e              s1_kind_q;
  logic signed [16:0] s1_err_q;
  logic signed [15:0] s1_integ_q;
  logic signed [17:0] s1_deriv_q;
  logic signed [15:0] s1_target_q;

  // stage 2: products
  logic               s2_valid_q;
  kind_e              s2_kind_q;
  logic signed [32:0] s2_mp_q;
  logic signed [31:0] s2_mi_q;
  logic signed [33:0] s2_md_q;
  logic signed [32:0] s2_mf_q;

  // stage 3: PID sum
  logic               s3_valid_q;
  kind_e              s3_kind_q;
  logic signed [35:0] s3_sum_q;
  logic signed [32:0] s3_mf_q;

  // stage 4: scale and clamp PID
  logic signed [35:0] sum_adj;
  logic signed [27:0] quo;
  logic signed [27:0] plim;
  logic signed [15:0] pid_d;
  logic               s4_valid_q;
  kind_e              s4_kind_q;
  logic signed [15:0] s4_pid_q;
  logic signed [32:0] s4_mf_q;

  // stage 5: add feedforward
  logic               s5_valid_q;
  kind_e              s5_kind_q;
  logic signed [33:0] s5_total_q;

  // output stage: clamp and scale total
  logic signed [33:0] tlim;
  logic signed [33:0] tclamp;
  logic signed [33:0] tadj;
  logic signed [15:0] drive_d;
  logic               out_valid_q;
  logic [15:0]        out_drive_q;
  logic               out_ok_q;

  assign adv   = !out_valid_q || m_axis_tready;
  assign pop_o = q_valid_i && adv;

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_drive_q;
  assign m_axis_tuser[0] = out_ok_q;

  always_comb begin
    idx      = q_entry_i.ch[ChIdxW-1:0];
    isum     = 18'(integ_q[idx]) + 18'(q_entry_i.err);
    ilim     = $signed({3'b000, cfg_i.int_limit});
    if (isum > ilim) begin
      integ_d = 16'(ilim);
    end else if (isum < -ilim) begin
      integ_d = 16'(-ilim);
    end else begin
      integ_d = 16'(isum);
    end
    prev_eff = first_q[idx] ? q_entry_i.err : prev_q[idx];
    deriv_d  = 18'(q_entry_i.err) - 18'(prev_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CHANNELS; k++) begin
        integ_q[k] <= '0;
        prev_q[k]  <= '0;
        first_q[k] <= 1'b1;
      end
    end else if (pop_o) begin
      unique case (q_entry_i.kind)
        KIND_STEP: begin
          integ_q[idx] <= integ_d;
          prev_q[idx]  <= q_entry_i.err;
          first_q[idx] <= 1'b0;
        end
        KIND_CLEAR: begin
          integ_q[idx] <= '0;
          prev_q[idx]  <= '0;
          first_q[idx] <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    sum_adj = s3_sum_q + (s3_sum_q[35] ? 36'sd255 : 36'sd0);
    quo     = 28'(sum_adj >>> 8);
    plim    = $signed({13'd0, cfg_i.out_limit});
    if (quo > plim) begin
      pid_d = 16'(plim);
    end else if (quo < -plim) begin
      pid_d = 16'(-plim);
    end else begin
      pid_d = 16'(quo);
    end
  end

  always_comb begin
    tlim = $signed({7'd0, cfg_i.out_limit, 12'd0});
    if (s5_total_q > tlim) begin
      tclamp = tlim;
    end else if (s5_total_q < -tlim) begin
      tclamp = -tlim;
    end else begin
      tclamp = s5_total_q;
    end
    tadj    = tclamp + (tclamp[33] ? 34'sd4095 : 34'sd0);
    drive_d = 16'(tadj >>> 12);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= q_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      out_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_kind_q   <= q_entry_i.kind;
      s1_err_q    <= q_entry_i.err;
      s1_integ_q  <= integ_d;
      s1_deriv_q  <= deriv_d;
      s1_target_q <= q_entry_i.target;

      s2_kind_q   <= s1_kind_q;
      s2_mp_q     <= 33'(cfg_i.gain_p) * 33'(s1_err_q);
      s2_mi_q     <= 32'(cfg_i.gain_i) * 32'(s1_integ_q);
      s2_md_q     <= 34'(cfg_i.gain_d) * 34'(s1_deriv_q);
      s2_mf_q     <= 33'(s1_target_q) * 33'($signed({1'b0, cfg_i.ff_gain}));

      s3_kind_q   <= s2_kind_q;
      s3_sum_q    <= 36'(s2_mp_q) + 36'(s2_mi_q) + 36'(s2_md_q);
      s3_mf_q     <= s2_mf_q;

      s4_kind_q   <= s3_kind_q;
      s4_pid_q    <= pid_d;
      s4_mf_q     <= s3_mf_q;

      s5_kind_q   <= s4_kind_q;
      s5_total_q  <= (34'(s4_pid_q) <<< 12) + 34'(s4_mf_q);

      out_drive_q <= (s5_kind_q == KIND_STEP) ? drive_d : 16'd0;
      out_ok_q    <= s5_kind_q != KIND_BAD;
    end
  end

endmodule

// ----- design/multi_channel_pid_speed_ff.sv -----
// ----------------------------------------------------------------------------
// multi_channel_pid_speed_ff
// Per-channel positional PID speed loop with feedforward and clamps.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one beat per control request. tuser carries the
//   channel and the mode (0 control step, 1 clear history), tdata the target
//   and measured speeds. Output stream (m_axis_*): one beat per input beat,
//   in order, with the drive value in tdata and channel_ok in tuser.
//   Configuration (cfg_*): register index and data, always ready; write only
//   while no request is in flight.
//   An accepted input beat passes the front register, queue, state update,
//   products, PID sum, PID clamp, feedforward add and output clamp, in that
//   order. One beat per cycle while m_axis_tready does not hold the pipeline;
//   the per-channel integral and previous error are updated in a single
//   stage, so requests to the same channel may follow each other directly.
//   Reset clears all channel history, sets gains and feedforward to zero and
//   the limits to 1000 (output) and 300 (integral).
//   When m_axis_tready is low the pipeline holds; the queue and front
//   register keep taking input beats until the queue fills.
// ----------------------------------------------------------------------------
module multi_channel_pid_speed_ff #(
  parameter int unsigned CHANNELS = mcpid_pkg::ChannelsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // speed_target, speed_measured
  input  logic [3:0]                    s_axis_tuser,  // channel, mode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,  // drive
  output logic [0:0]                    m_axis_tuser,  // channel_ok
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mcpid_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);
  import mcpid_pkg::*;

  cfg_t   cfg_q;
  logic   push;
  logic   full;
  logic   pop;
  logic   q_valid;
  entry_t front_entry;
  entry_t q_entry;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p    <= '0;
      cfg_q.gain_i    <= '0;
      cfg_q.gain_d    <= '0;
      cfg_q.ff_gain   <= '0;
      cfg_q.out_limit <= OutLimitReset;
      cfg_q.int_limit <= IntLimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_GAIN_P:    cfg_q.gain_p    <= $signed(cfg_data_i);
        REG_GAIN_I:    cfg_q.gain_i    <= $signed(cfg_data_i);
        REG_GAIN_D:    cfg_q.gain_d    <= $signed(cfg_data_i);
        REG_FF_GAIN:   cfg_q.ff_gain   <= cfg_data_i;
        REG_OUT_LIMIT: cfg_q.out_limit <= cfg_data_i[14:0];
        REG_INT_LIMIT: cfg_q.int_limit <= cfg_data_i[14:0];
        default: begin
        end
      endcase
    end
  end

  mcpid_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_o        (push),
    .entry_o       (front_entry),
    .full_i        (full)
  );

  mcpid_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  mcpid_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-channel PID speed loop with feedforward.
// A scoreboard predicts the drive of every accepted request from its own copy
// of the channel history and registers; output beats are compared in order.
// Directed requests hit the field extremes, clears, bad channels and first
// steps, then random requests run under several register settings with
// bursty input, random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------

class pid_scoreboard;

  typedef struct packed {
    logic [15:0] drive;
    logic        ok;
  } drive_beat_t;

  localparam int unsigned Channels = mcpid_pkg::ChannelsDefault;

  logic signed [15:0] gain_p;
  logic signed [15:0] gain_i;
  logic signed [15:0] gain_d;
  logic        [15:0] ff_gain;
  logic        [14:0] out_limit;
  logic        [14:0] int_limit;

  longint      integ_acc[Channels];
  longint      last_err[Channels];
  bit          fresh[Channels];
  drive_beat_t drive_q[$];
  int          errors;

  function new();
    gain_p    = '0;
    gain_i    = '0;
    gain_d    = '0;
    ff_gain   = '0;
    out_limit = mcpid_pkg::OutLimitReset;
    int_limit = mcpid_pkg::IntLimitReset;
    for (int k = 0; k < Channels; k++) begin
      integ_acc[k] = 0;
      last_err[k]  = 0;
      fresh[k]     = 1'b1;
    end
    errors = 0;
  endfunction

  function longint saturate(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function void write_reg(logic [mcpid_pkg::CfgIdxW-1:0] idx, logic [15:0] data);
    case (idx)
      mcpid_pkg::REG_GAIN_P:    gain_p    = data;
      mcpid_pkg::REG_GAIN_I:    gain_i    = data;
      mcpid_pkg::REG_GAIN_D:    gain_d    = data;
      mcpid_pkg::REG_FF_GAIN:   ff_gain   = data;
      mcpid_pkg::REG_OUT_LIMIT: out_limit = data[14:0];
      mcpid_pkg::REG_INT_LIMIT: int_limit = data[14:0];
      default: ;
    endcase
  endfunction

  function void note_request(logic [2:0] ch, logic md, logic signed [15:0] tgt,
                             logic signed [15:0] meas);
    longint      err;
    longint      acc;
    longint      deriv;
    longint      sum;
    longint      pid;
    longint      total;
    drive_beat_t beat;
    beat.drive = '0;
    beat.ok    = 1'b0;
    if (ch < Channels) begin
      beat.ok = 1'b1;
      if (md) begin
        integ_acc[ch] = 0;
        last_err[ch]  = 0;
        fresh[ch]     = 1'b1;
      end else begin
        err = longint'(tgt) - longint'(meas);
        if (fresh[ch]) begin
          last_err[ch] = err;
          fresh[ch]    = 1'b0;
        end
        acc = saturate(integ_acc[ch] + err, longint'(int_limit));
        integ_acc[ch] = acc;
        deriv = err - last_err[ch];
        last_err[ch] = err;
        sum = longint'(gain_p) * err + longint'(gain_i) * acc + longint'(gain_d) * deriv;
        pid = saturate(sum / 256, longint'(out_limit));
        total = pid * 4096 + longint'(tgt) * longint'(ff_gain);
        total = saturate(total, longint'(out_limit) * 4096) / 4096;
        beat.drive = total[15:0];
      end
    end
    drive_q.push_back(beat);
  endfunction

  function void check_drive(logic [15:0] drive, logic ok);
    drive_beat_t want;
    if (drive_q.size() == 0) begin
      $error("output beat with no request pending: drive %0d", $signed(drive));
      errors++;
      return;
    end
    want = drive_q.pop_front();
    if (drive !== want.drive) begin
      $error("drive: expected %0d, got %0d", $signed(want.drive), $signed(drive));
      errors++;
    end
    if (ok !== want.ok) begin
      $error("channel_ok: expected %0b, got %0b", want.ok, ok);
      errors++;
    end
  endfunction

  function int pending();
    return drive_q.size();
  endfunction

endclass

module tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 16;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [31:0]                   s_axis_tdata;   // speed_target, speed_measured
  logic [3:0]                    s_axis_tuser;   // channel, mode
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [15:0]                   m_axis_tdata;   // drive
  logic [0:0]                    m_axis_tuser;   // channel_ok
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [mcpid_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [15:0]                   cfg_data_i;

  pid_scoreboard sb = new();
  int unsigned   cycle_count = 0;
  int            burst_left = 0;
  bit            hold_request = 1'b0;

  multi_channel_pid_speed_ff i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CycleLimit);
    $display("Simulation FAILED");
    $finish;
  end

  // beat monitors
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_request(s_axis_tuser[2:0], s_axis_tuser[3], s_axis_tdata[15:0],
                        s_axis_tdata[31:16]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_drive(m_axis_tdata, m_axis_tuser[0]);
      end
    end
  end

  // output side: changing stall styles, plus one long hold-off on request
  initial begin
    int rx_style;
    int style_left;
    int hold_left;
    bit hold_done;
    int unsigned tick;
    rx_style   = 0;
    style_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    tick       = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_request && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (style_left == 0) begin
        rx_style   = $urandom_range(3);
        style_left = $urandom_range(300, 50);
      end
      style_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_style)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= $urandom_range(1);
          2: m_axis_tready <= ($urandom_range(3) == 0);
          default: m_axis_tready <= (tick % 5 != 3);
        endcase
      end
    end
  end

  task automatic offer_request(logic [2:0] ch, logic md, logic signed [15:0] tgt,
                               logic signed [15:0] meas);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {meas, tgt};
    s_axis_tuser  <= {md, ch};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic random_request();
    logic [2:0]         ch;
    logic               md;
    logic signed [15:0] tgt;
    logic signed [15:0] meas;
    ch = ($urandom_range(99) < 6) ? 3'($urandom_range(7, 4)) : 3'($urandom_range(3));
    md = ($urandom_range(99) < 5);
    case ($urandom_range(3))
      0: begin
        tgt  = $urandom;
        meas = $urandom;
      end
      1: begin
        tgt  = 16'($urandom_range(4000) - 2000);
        meas = tgt + 16'($urandom_range(400) - 200);
      end
      2: begin
        tgt  = ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
        meas = ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
      end
      default: begin
        tgt  = 16'($urandom_range(20000) - 10000);
        meas = 16'($urandom_range(20000) - 10000);
      end
    endcase
    offer_request(ch, md, tgt, meas);
  endtask

  task automatic write_reg(logic [mcpid_pkg::CfgIdxW-1:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_settings(logic [15:0] gp, logic [15:0] gi, logic [15:0] gd,
                                logic [15:0] ff, logic [14:0] ol, logic [14:0] il);
    write_reg(mcpid_pkg::REG_GAIN_P, gp);
    write_reg(mcpid_pkg::REG_GAIN_I, gi);
    write_reg(mcpid_pkg::REG_GAIN_D, gd);
    write_reg(mcpid_pkg::REG_FF_GAIN, ff);
    write_reg(mcpid_pkg::REG_OUT_LIMIT, {1'b0, ol});
    write_reg(mcpid_pkg::REG_INT_LIMIT, {1'b0, il});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_settings();
    logic [15:0] v[6];
    for (int k = 0; k < 6; k++) begin
      case ($urandom_range(7))
        0: v[k] = 16'hffff;
        1: v[k] = 16'h8000;
        2: v[k] = 16'h7fff;
        3: v[k] = $urandom;
        4: v[k] = '0;
        default: v[k] = (k < 4) ? 16'($urandom_range(1536) - 512) : 16'($urandom_range(2000));
      endcase
    end
    apply_settings(v[0], v[1], v[2], v[3], v[4][14:0], v[5][14:0]);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = mcpid_pkg::REG_GAIN_P;
    cfg_data_i    = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apply_settings(16'd256, 16'd64, 16'd128, 16'h0200, 15'd1000, 15'd300);
    offer_request(3'd0, 1'b0, 16'sd1000, 16'sd0);        // first step, no derivative
    offer_request(3'd0, 1'b0, 16'sd1000, 16'sd200);
    offer_request(3'd0, 1'b0, 16'sd1000, 16'sd900);
    offer_request(3'd1, 1'b0, 16'sh7fff, 16'sh8000);     // largest positive error
    offer_request(3'd1, 1'b0, 16'sh8000, 16'sh7fff);     // largest negative error
    offer_request(3'd2, 1'b0, 16'sh8000, 16'sh8000);
    offer_request(3'd3, 1'b0, -16'sd1, 16'sd0);
    offer_request(3'd4, 1'b0, 16'sd500, 16'sd0);         // bad channels
    offer_request(3'd5, 1'b1, 16'sd500, 16'sd0);
    offer_request(3'd6, 1'b0, 16'sh7fff, 16'sh8000);
    offer_request(3'd7, 1'b1, -16'sd1, -16'sd1);
    offer_request(3'd0, 1'b1, 16'sd0, 16'sd0);           // clear, then fresh start
    offer_request(3'd0, 1'b0, 16'sd300, 16'sd0);
    offer_request(3'd0, 1'b0, 16'sd300, 16'sd100);
    drain();

    apply_settings(16'h8000, 16'h8000, 16'h8000, 16'hffff, 15'h7fff, 15'h7fff);
    offer_request(3'd0, 1'b0, 16'sh7fff, 16'sh8000);
    offer_request(3'd0, 1'b0, 16'sh7fff, 16'sh8000);
    offer_request(3'd1, 1'b0, 16'sh8000, 16'sh7fff);
    offer_request(3'd2, 1'b0, 16'sh7fff, 16'sh7fff);
    offer_request(3'd3, 1'b0, 16'sh8000, 16'sd0);
    drain();

    apply_settings(16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 15'd0, 15'd0);
    offer_request(3'd1, 1'b0, 16'sh7fff, 16'sh8000);
    offer_request(3'd2, 1'b0, 16'sd1234, 16'sd0);
    offer_request(3'd3, 1'b0, 16'sh8000, 16'sh7fff);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 1) begin
        apply_settings(16'd300, 16'd40, 16'd600, 16'h0100, 15'd2000, 15'd500);
      end else begin
        random_settings();
      end
      for (int n = 0; n < 200; n++) begin
        if (phase == 1 && n == 40) hold_request = 1'b1;
        random_request();
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
